>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and muted in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define CMFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true out of reset.
`define CMFT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> hdl/cmft_pkg.sv
// ---------------------------------------------------------------------------
// cmft_pkg
// Types and constants of the motor feedback multi-turn tracker.
// ---------------------------------------------------------------------------
`default_nettype none

package cmft_pkg;

  localparam int FRAME_ID_W = 29;
  localparam int PAYLOAD_W  = 64;
  localparam int DLC_W      = 4;
  localparam int MIDX_W     = 3;
  localparam int ANGLE_W    = 16;
  localparam int TURN_W     = 32;
  localparam int POS_W      = 48;
  localparam int WORD_W     = 16;
  localparam int OFFSET_W   = 13;
  localparam int MOTOR_SLOTS = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = OFFSET_W;

  localparam int DEFAULT_ENCODER_COUNTS = 8192;
  localparam int DEFAULT_MOTOR_COUNT    = 8;

  localparam logic [FRAME_ID_W-1:0] FIRST_ID = 29'h201;
  localparam logic [FRAME_ID_W-1:0] LAST_ID  = 29'h208;
  localparam logic [DLC_W-1:0]      DLC_FULL = 4'd8;

  typedef struct packed {
    logic [FRAME_ID_W-1:0] frame_id;
    logic [PAYLOAD_W-1:0]  payload;
    logic [DLC_W-1:0]      frame_length;
    logic                  is_extended;
    logic                  is_remote;
  } cmft_frame_t;

  typedef struct packed {
    logic                     accepted;
    logic [MIDX_W-1:0]        motor_index;
    logic signed [POS_W-1:0]  multi_turn_position;
    logic signed [TURN_W-1:0] turn_count;
    logic signed [WORD_W-1:0] raw_speed;
    logic signed [WORD_W-1:0] raw_current;
  } cmft_fb_t;

  // one word per motor in the state RAM
  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [TURN_W-1:0]  turns;
  } cmft_state_t;

endpackage

`default_nettype wire

>>> hdl/cmft_stream_if.sv
// ---------------------------------------------------------------------------
// cmft_stream_if
// Valid/ready channel carrying one payload beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface cmft_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/cmft_ram.sv
// ---------------------------------------------------------------------------
// cmft_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module cmft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/can_motor_feedback_multiturn_tracker.sv
// ---------------------------------------------------------------------------
// can_motor_feedback_multiturn_tracker
// Unwraps motor encoder angles from bus feedback frames into multi-turn
// positions, one frame per cycle unless out_ch stalls.
// ---------------------------------------------------------------------------
// Usage:
//  - in_ch takes one received frame per beat (id, 8 data bytes, DLC,
//    extended and remote flags). out_ch gives one result beat per frame.
//  - Standard 8-byte data frames with id 0x201 + n, n < MOTOR_COUNT, update
//    motor n; any other frame yields a beat with every field zero.
//  - cfg_we/cfg_idx/cfg_wdata set the per-motor zero offsets; write only
//    while no frame is in flight.
//  - Pipeline: a frame passes stage 1, stage 2 and the output register.
//  - Throughput: one frame per cycle unless out_ch stalls, also on
//    back-to-back frames for one motor; the per-motor read-modify-write
//    of the state RAM is bypassed from the last write: no interlock.
//  - Stall: the three stages hold while out_ch.ready is low; in_ch.ready
//    drops only once all stages are full.
//  - Reset: offsets go to zero and per-motor valid bits are cleared, so
//    every motor reads as angle 0, turn 0. No RAM clearing pass is run;
//    the block takes frames right after reset.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module can_motor_feedback_multiturn_tracker #(
  parameter int ENCODER_COUNTS = cmft_pkg::DEFAULT_ENCODER_COUNTS,
  parameter int MOTOR_COUNT    = cmft_pkg::DEFAULT_MOTOR_COUNT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cmft_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [cmft_pkg::CFG_DATA_W-1:0] cfg_wdata,
  cmft_stream_if.sink                   in_ch,
  cmft_stream_if.source                 out_ch
);

  localparam int AW      = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int ANGLE_W = cmft_pkg::ANGLE_W;
  localparam int TURN_W  = cmft_pkg::TURN_W;
  localparam int POS_W   = cmft_pkg::POS_W;
  localparam int MIDX_W  = cmft_pkg::MIDX_W;
  localparam int WORD_W  = cmft_pkg::WORD_W;
  localparam int ECW     = $clog2(ENCODER_COUNTS + 1);
  localparam int PROD_W  = TURN_W + ECW + 1;
  localparam int BASE_W  = ANGLE_W + 2;

  localparam logic [ECW-1:0] EC_U = ECW'(ENCODER_COUNTS);
  localparam logic signed [ANGLE_W:0] HALF_S = (ANGLE_W + 1)'(ENCODER_COUNTS / 2);
  localparam logic signed [ANGLE_W:0] NHALF_S = -HALF_S;

  // ---------------- configuration: per-motor offsets ----------------
  logic [cmft_pkg::OFFSET_W-1:0] offset_r [cmft_pkg::MOTOR_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cmft_pkg::MOTOR_SLOTS; i++) begin
        offset_r[i] <= '0;
      end
    end else if (cfg_we) begin
      offset_r[cfg_idx] <= cfg_wdata;
    end
  end

  // ---------------- pipeline control ----------------
  logic s1_v_r, s2_v_r, out_v_r;
  logic out_free, s2_free, s2_go, s1_free, s1_go, in_fire;

  assign out_free = !out_v_r || out_ch.ready;
  assign s2_go    = s2_v_r && out_free;
  assign s2_free  = !s2_v_r || out_free;
  assign s1_go    = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_fire  = in_ch.valid && s1_free;
  assign in_ch.ready = s1_free;

  // ---------------- stage 0: decode, issue RAM read ----------------
  cmft_pkg::cmft_frame_t     fr;
  logic [cmft_pkg::FRAME_ID_W-1:0] id_off;
  logic [MIDX_W-1:0]         in_m;
  logic                      in_acc;

  assign fr     = in_ch.data;
  assign id_off = fr.frame_id - cmft_pkg::FIRST_ID;
  assign in_m   = id_off[MIDX_W-1:0];
  assign in_acc = !fr.is_extended && !fr.is_remote &&
                  (fr.frame_length == cmft_pkg::DLC_FULL) &&
                  (fr.frame_id >= cmft_pkg::FIRST_ID) &&
                  (fr.frame_id <= cmft_pkg::LAST_ID) &&
                  ({1'b0, in_m} < (MIDX_W + 1)'(MOTOR_COUNT));

  // state RAM, read at accept, written from stage 1
  logic                  wr_en;
  cmft_pkg::cmft_state_t wr_data;
  logic [$bits(cmft_pkg::cmft_state_t)-1:0] ram_q;
  logic [MIDX_W-1:0]     s1_m_r;

  cmft_ram #(
    .WIDTH ($bits(cmft_pkg::cmft_state_t)),
    .DEPTH (MOTOR_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_m_r[AW-1:0]),
    .wdata (wr_data),
    .re    (in_fire && in_acc),
    .raddr (in_m[AW-1:0]),
    .rdata (ram_q)
  );

  // entries never written read as zero
  logic [MOTOR_COUNT-1:0] seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (wr_en) begin
      seen_r[s1_m_r[AW-1:0]] <= 1'b1;
    end
  end

  // ---------------- stage 1: unwrap, write back ----------------
  logic                s1_acc_r, s1_hit_r, s1_seen_r;
  logic [ANGLE_W-1:0]  s1_angle_r;
  logic [WORD_W-1:0]   s1_speed_r, s1_cur_r;
  cmft_pkg::cmft_state_t fwd_r;
  logic [MIDX_W-1:0]   fwd_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_acc_r   <= in_acc;
      s1_m_r     <= in_m;
      s1_angle_r <= fr.payload[63:48];
      s1_speed_r <= fr.payload[47:32];
      s1_cur_r   <= fr.payload[31:16];
      // same-motor write at this edge: RAM read is stale, take the bypass
      s1_hit_r   <= wr_en && (s1_m_r == in_m);
      s1_seen_r  <= in_acc && seen_r[in_m[AW-1:0]];
    end
    if (wr_en) begin
      fwd_r   <= wr_data;
      fwd_m_r <= s1_m_r;
    end
  end

  cmft_pkg::cmft_state_t   cur;
  logic signed [ANGLE_W:0] delta;
  logic [TURN_W-1:0]       turns_nxt;
  logic signed [BASE_W-1:0] base;

  always_comb begin
    if (s1_hit_r) begin
      cur = fwd_r;
    end else if (s1_seen_r) begin
      cur = ram_q;
    end else begin
      cur = '0;
    end
    delta = $signed({1'b0, s1_angle_r}) - $signed({1'b0, cur.angle});
    if (delta > HALF_S) begin
      turns_nxt = cur.turns - TURN_W'(1);
    end else if (delta < NHALF_S) begin
      turns_nxt = cur.turns + TURN_W'(1);
    end else begin
      turns_nxt = cur.turns;
    end
    base = $signed(BASE_W'(s1_angle_r)) - $signed(BASE_W'(offset_r[s1_m_r]));
  end

  assign wr_en         = s1_go && s1_acc_r;
  assign wr_data.angle = s1_angle_r;
  assign wr_data.turns = turns_nxt;

  // ---------------- stage 2: scale to position ----------------
  logic                 s2_acc_r;
  logic [MIDX_W-1:0]    s2_m_r;
  logic [TURN_W-1:0]    s2_turns_r;
  logic signed [BASE_W-1:0] s2_base_r;
  logic [WORD_W-1:0]    s2_speed_r, s2_cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_acc_r   <= s1_acc_r;
      s2_m_r     <= s1_m_r;
      s2_turns_r <= turns_nxt;
      s2_base_r  <= base;
      s2_speed_r <= s1_speed_r;
      s2_cur_r   <= s1_cur_r;
    end
  end

  logic signed [PROD_W-1:0] prod;
  logic signed [POS_W-1:0]  pos;

  // constant multiplier: turns times the encoder count
  assign prod = PROD_W'($signed(s2_turns_r)) * PROD_W'($signed({1'b0, EC_U}));
  assign pos  = POS_W'(prod) + POS_W'(s2_base_r);

  // ---------------- output register ----------------
  cmft_pkg::cmft_fb_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      if (s2_acc_r) begin
        out_r.accepted            <= 1'b1;
        out_r.motor_index         <= s2_m_r;
        out_r.multi_turn_position <= pos;
        out_r.turn_count          <= $signed(s2_turns_r);
        out_r.raw_speed           <= $signed(s2_speed_r);
        out_r.raw_current         <= $signed(s2_cur_r);
      end else begin
        out_r <= '0;
      end
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  // ---------------- assertions ----------------
  `CMFT_ASSERT(a_bypass_same_motor, (s1_v_r && s1_hit_r) |-> (s1_m_r == fwd_m_r), "bypass motor mismatch")
  `CMFT_ASSERT(a_turn_step, wr_en |-> ((turns_nxt == cur.turns) || (turns_nxt == cur.turns + 32'd1) || (turns_nxt == cur.turns - 32'd1)), "turn count moved by more than one")
  `CMFT_ASSERT(a_reject_zero, (out_v_r && !out_r.accepted) |-> ((out_r.turn_count == 0) && (out_r.multi_turn_position == 0) && (out_r.motor_index == 0)), "rejected beat not zero")
  `CMFT_NEVER(a_stall_empty, !in_ch.ready && !(s1_v_r && s2_v_r && out_v_r), "input stalled with a free stage")

endmodule

`default_nettype wire

>>> sim/tb_can_motor_feedback_multiturn_tracker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_can_motor_feedback_multiturn_tracker
// Drives bus feedback frames into the multi-turn tracker and compares every
// result beat against a typed row or an in-bench per-motor angle unwrap model.
// ---------------------------------------------------------------------------
// Flow:
//  - reset, then a directed frame table run with offsets at their reset value
//  - three random phases, each after an offset reprogram while idle:
//    sender 10% idle / receiver 81% idle, then swapped, then no idling
//  - random frames are mostly well-formed motor feedback with angle moves
//    chosen to spin motors forward/backward, sit on the half-turn boundary
//    or jump anywhere in the 16-bit word; the rest is rejected-frame noise
// ---------------------------------------------------------------------------

module tb_can_motor_feedback_multiturn_tracker;

  localparam int FRAME_ID_W  = cmft_pkg::FRAME_ID_W;
  localparam int PAYLOAD_W   = cmft_pkg::PAYLOAD_W;
  localparam int DLC_W       = cmft_pkg::DLC_W;
  localparam int MIDX_W      = cmft_pkg::MIDX_W;
  localparam int ANGLE_W     = cmft_pkg::ANGLE_W;
  localparam int TURN_W      = cmft_pkg::TURN_W;
  localparam int POS_W       = cmft_pkg::POS_W;
  localparam int OFFSET_W    = cmft_pkg::OFFSET_W;
  localparam int MOTOR_SLOTS = cmft_pkg::MOTOR_SLOTS;
  localparam int CFG_IDX_W   = cmft_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = cmft_pkg::CFG_DATA_W;

  localparam logic [FRAME_ID_W-1:0] FIRST_ID = cmft_pkg::FIRST_ID;
  localparam logic [FRAME_ID_W-1:0] LAST_ID  = cmft_pkg::LAST_ID;
  localparam logic [DLC_W-1:0]      DLC_FULL = cmft_pkg::DLC_FULL;

  typedef cmft_pkg::cmft_frame_t cmft_frame_t;
  typedef cmft_pkg::cmft_fb_t    cmft_fb_t;

  localparam int ENC_COUNTS   = cmft_pkg::DEFAULT_ENCODER_COUNTS;
  localparam int MOTORS       = cmft_pkg::DEFAULT_MOTOR_COUNT;
  localparam int HALF_TURN    = ENC_COUNTS / 2;
  localparam int SETTLE_CYCLES = 8;       // pipeline is 3 deep, margin on top
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_CAP    = 40;       // mismatch lines shown, all are counted
  localparam int PHASE_FRAMES = 210;

  typedef enum int {OFFS_MAX, OFFS_RANDOM, OFFS_MIXED} offset_plan_t;

  // one directed frame; typed rows carry their expected beat, others use the model
  typedef struct {
    logic [FRAME_ID_W-1:0] id;
    logic [PAYLOAD_W-1:0]  data;
    logic [DLC_W-1:0]      dlc;
    bit                    ext;
    bit                    rtr;
    bit                    typed;
    cmft_fb_t              fb;
  } frame_row_t;

  localparam cmft_fb_t FB_NONE = '0;
  localparam logic [PAYLOAD_W-1:0] ONES = '1;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cmft_stream_if #(.T(cmft_frame_t)) in_ch ();
  cmft_stream_if #(.T(cmft_fb_t))    out_ch ();

  can_motor_feedback_multiturn_tracker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // model state: last raw angle word, turn count and zero offset per motor
  logic [ANGLE_W-1:0]  motor_angle [MOTOR_SLOTS];
  logic [TURN_W-1:0]   motor_turns [MOTOR_SLOTS];
  logic [OFFSET_W-1:0] motor_offset [MOTOR_SLOTS];

  cmft_fb_t expected_fb [$];

  int in_idle_pct;
  int out_idle_pct;
  int mismatch_count;
  int cycle_count;
  int frames_sent;
  int motor_updates;
  int beats_checked;

  // Directed frames. Offsets are all zero here.
  // Rows 0..2: first frames on motors 0 and 7, incl. a full backward wrap.
  // Rejects: id just outside the range, extended, remote, wrong DLC,
  // ids whose low bits look right but upper bits are set.
  // Then: angle word above the encoder range, exact half-turn jumps (no
  // change) and one count past them (turn moves), remaining motors.
  frame_row_t directed_frames [25] = '{
    '{29'h201, 64'h0000_7FFF_8000_0000, 4'd8, 1'b0, 1'b0, 1'b1,
      '{1'b1, 3'd0, 48'h0, 32'h0, 16'h7FFF, 16'h8000}},
    '{29'h208, 64'h1FFF_8000_7FFF_FFFF, 4'd8, 1'b0, 1'b0, 1'b1,
      '{1'b1, 3'd7, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF}},
    '{29'h208, 64'h0, 4'd8, 1'b0, 1'b0, 1'b1,
      '{1'b1, 3'd7, 48'h0, 32'h0, 16'h0, 16'h0}},
    '{29'h200,       ONES, 4'd8,  1'b0, 1'b0, 1'b1, FB_NONE},
    '{29'h209,       ONES, 4'd8,  1'b0, 1'b0, 1'b1, FB_NONE},
    '{29'h201,       ONES, 4'd8,  1'b1, 1'b0, 1'b1, FB_NONE},
    '{29'h201,       ONES, 4'd8,  1'b0, 1'b1, 1'b1, FB_NONE},
    '{29'h201,       ONES, 4'd0,  1'b1, 1'b1, 1'b1, FB_NONE},
    '{29'h201,       ONES, 4'd7,  1'b0, 1'b0, 1'b1, FB_NONE},
    '{29'h201,       ONES, 4'd9,  1'b0, 1'b0, 1'b1, FB_NONE},
    '{29'h201,       ONES, 4'd15, 1'b0, 1'b0, 1'b1, FB_NONE},
    '{29'h1FFF_FFFF, ONES, 4'd8,  1'b0, 1'b0, 1'b1, FB_NONE},
    '{29'h1000_0201, ONES, 4'd8,  1'b0, 1'b0, 1'b1, FB_NONE},
    '{29'h0,         64'h0, 4'd0, 1'b0, 1'b0, 1'b1, FB_NONE},
    '{29'h202, ONES,                  4'd8, 1'b0, 1'b0, 1'b0, FB_NONE},
    '{29'h202, 64'h0,                 4'd8, 1'b0, 1'b0, 1'b0, FB_NONE},
    '{29'h203, 64'h1000_0123_4567_89AB, 4'd8, 1'b0, 1'b0, 1'b0, FB_NONE},
    '{29'h203, 64'h0000_FEDC_BA98_7654, 4'd8, 1'b0, 1'b0, 1'b0, FB_NONE},
    '{29'h203, 64'h1001_5555_AAAA_0000, 4'd8, 1'b0, 1'b0, 1'b0, FB_NONE},
    '{29'h203, 64'h0000_AAAA_5555_FFFF, 4'd8, 1'b0, 1'b0, 1'b0, FB_NONE},
    '{29'h204, 64'h1FFF_1234_5678_9ABC, 4'd8, 1'b0, 1'b0, 1'b0, FB_NONE},
    '{29'h205, 64'h0800_8001_7FFE_0F0F, 4'd8, 1'b0, 1'b0, 1'b0, FB_NONE},
    '{29'h206, 64'hE000_0001_FFFF_F0F0, 4'd8, 1'b0, 1'b0, 1'b0, FB_NONE},
    '{29'h207, 64'h0FFF_FFFF_0001_3C3C, 4'd8, 1'b0, 1'b0, 1'b0, FB_NONE},
    '{29'h201, 64'h0800_0000_0000_0000, 4'd8, 1'b0, 1'b0, 1'b0, FB_NONE}
  };

  // -------------------------------------------------------------------------
  // Model: unwrap one frame, update motor state, return the result beat.
  // -------------------------------------------------------------------------
  function automatic cmft_fb_t track_frame(input cmft_frame_t f);
    cmft_fb_t            fb;
    int unsigned         m;
    logic [ANGLE_W-1:0]  ang;
    logic signed [ANGLE_W:0] jump;
    logic [POS_W-1:0]    turns_wide;
    fb = FB_NONE;
    if (f.is_extended || f.is_remote || f.frame_length != DLC_FULL)
      return fb;
    if (f.frame_id < FIRST_ID || f.frame_id > LAST_ID)
      return fb;
    m = 32'(f.frame_id - FIRST_ID);
    if (m >= MOTORS)
      return fb;

    ang  = f.payload[63:48];
    jump = $signed({1'b0, ang}) - $signed({1'b0, motor_angle[m]});
    // forward jump past half a turn means we crossed zero going backward
    if (jump > HALF_TURN)
      motor_turns[m] = motor_turns[m] - TURN_W'(1);
    else if (jump < -HALF_TURN)
      motor_turns[m] = motor_turns[m] + TURN_W'(1);
    motor_angle[m] = ang;

    turns_wide = {{(POS_W-TURN_W){motor_turns[m][TURN_W-1]}}, motor_turns[m]};
    fb.accepted            = 1'b1;
    fb.motor_index         = m[MIDX_W-1:0];
    fb.multi_turn_position = turns_wide * POS_W'(ENC_COUNTS) + POS_W'(ang)
                             - POS_W'(motor_offset[m]);
    fb.turn_count          = motor_turns[m];
    fb.raw_speed           = f.payload[47:32];
    fb.raw_current         = f.payload[31:16];
    return fb;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // -------------------------------------------------------------------------
  // Clock, cycle limit, receiver and result checker
  // -------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still expected",
               cycle_count, expected_fb.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    cmft_fb_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_fb.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_fb.pop_front();
        beats_checked++;
        check_field("accepted",    64'(out_ch.data.accepted),            64'(want.accepted));
        check_field("motor_index", 64'(out_ch.data.motor_index),         64'(want.motor_index));
        check_field("position",    64'(out_ch.data.multi_turn_position),
                    64'(want.multi_turn_position));
        check_field("turn_count",  64'(out_ch.data.turn_count),          64'(want.turn_count));
        check_field("raw_speed",   64'(out_ch.data.raw_speed),           64'(want.raw_speed));
        check_field("raw_current", 64'(out_ch.data.raw_current),         64'(want.raw_current));
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------

  // Present one frame, hold it until taken, then queue its expected beat.
  task automatic send_frame(input cmft_frame_t f, input bit typed,
                            input cmft_fb_t typed_fb);
    cmft_fb_t fb;
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= f;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    fb = track_frame(f);
    expected_fb.push_back(typed ? typed_fb : fb);
    frames_sent++;
    if (fb.accepted)
      motor_updates++;
  endtask

  // Drop valid and wait until every beat is back and the pipe is empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_fb.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Rewrite all eight zero offsets, back to back; only called while idle.
  task automatic program_offsets(input offset_plan_t plan);
    logic [OFFSET_W-1:0] val;
    for (int i = 0; i < MOTOR_SLOTS; i++) begin
      case (plan)
        OFFS_MAX:    val = '1;
        OFFS_RANDOM: val = OFFSET_W'($urandom);
        default:     val = (i % 2 == 0) ? '0 : OFFSET_W'($urandom);
      endcase
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_IDX_W'(i);
      cfg_wdata <= val;
      motor_offset[i] = val;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Random frames until `count` well-formed ones went out; ~15% noise on top.
  task automatic run_random(input int count);
    int                 good;
    int unsigned        m;
    int                 step;
    logic [ANGLE_W-1:0] last;
    logic [ANGLE_W-1:0] ang;
    cmft_frame_t        f;
    good = 0;
    while (good < count) begin
      m              = $urandom_range(MOTORS - 1);
      f.frame_id     = FIRST_ID + FRAME_ID_W'(m);
      f.payload      = {$urandom, $urandom};
      f.frame_length = DLC_FULL;
      f.is_extended  = 1'b0;
      f.is_remote    = 1'b0;
      if ($urandom_range(99) < 15) begin
        case ($urandom_range(3))
          0: begin
            f.frame_id     = FRAME_ID_W'($urandom);
            f.frame_length = DLC_W'($urandom);
            f.is_extended  = 1'($urandom);
            f.is_remote    = 1'($urandom);
          end
          1: f.frame_length = DLC_FULL + DLC_W'($urandom_range(1, 15));
          2: {f.is_extended, f.is_remote} = 2'($urandom_range(1, 3));
          default: f.frame_id = $urandom_range(1) ? FIRST_ID - FRAME_ID_W'(1)
                                                  : LAST_ID + FRAME_ID_W'(1);
        endcase
      end else begin
        last = motor_angle[m];
        step = $urandom_range(500, 4000);
        case ($urandom_range(9)) inside
          [0:3]: ang = ANGLE_W'((int'(last) % ENC_COUNTS + step) % ENC_COUNTS);
          [4:5]: ang = ANGLE_W'((int'(last) % ENC_COUNTS + ENC_COUNTS - step)
                                % ENC_COUNTS);
          // straddle the half-turn threshold in either direction
          6: begin
            step = HALF_TURN - 1 + $urandom_range(2);
            ang  = $urandom_range(1) ? last + ANGLE_W'(step) : last - ANGLE_W'(step);
          end
          7: ang = ANGLE_W'($urandom_range(ENC_COUNTS - 1));
          8: ang = ANGLE_W'($urandom);
          default: ang = last;
        endcase
        f.payload[63:48] = ang;
        good++;
      end
      send_frame(f, 1'b0, FB_NONE);
    end
  endtask

  initial begin
    cmft_frame_t f;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= '0;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    for (int i = 0; i < MOTOR_SLOTS; i++) begin
      motor_angle[i]  = '0;
      motor_turns[i]  = '0;
      motor_offset[i] = '0;
    end
    in_idle_pct  = 10;
    out_idle_pct = 81;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_frames[i]) begin
      f.frame_id     = directed_frames[i].id;
      f.payload      = directed_frames[i].data;
      f.frame_length = directed_frames[i].dlc;
      f.is_extended  = directed_frames[i].ext;
      f.is_remote    = directed_frames[i].rtr;
      send_frame(f, directed_frames[i].typed, directed_frames[i].fb);
    end
    settle();

    program_offsets(OFFS_MAX);
    run_random(PHASE_FRAMES);
    settle();

    in_idle_pct  = 81;
    out_idle_pct = 10;
    program_offsets(OFFS_RANDOM);
    run_random(PHASE_FRAMES);
    settle();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    program_offsets(OFFS_MIXED);
    run_random(PHASE_FRAMES);
    settle();

    $display("Sent %0d frames (%0d motor updates, %0d dropped), %0d result beats checked",
             frames_sent, motor_updates, frames_sent - motor_updates, beats_checked);
    $display("Offsets swept max/random/zero-mixed under three stall mixes, %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
